// File: rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg: shared types and control store for the fraction reduce/add block
// Holds the micro-operation codes, jump conditions, control word layout and
// the read-only program that sequences the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 32;
    localparam int PC_W      = 4;

    // Command codes carried on the cmd field.
    localparam logic CMD_REDUCE = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    typedef logic [NUM_OUT_W-1:0] t_num_out;
    typedef logic [DEN_OUT_W-1:0] t_den_out;
    typedef logic [PC_W-1:0]      t_pc;

    // Datapath micro-operations.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_DIV_INIT_N,
        OP_DIV_INIT_D,
        OP_DIV_STEP,
        OP_STORE_N,
        OP_STORE_D,
        OP_SEL_NEXT,
        OP_MUL_1,
        OP_MUL_2,
        OP_MUL_3
    } t_op;

    // Jump conditions. A taken jump loads the target, otherwise the
    // program counter advances (and wraps after the emit step).
    typedef enum logic [2:0] {
        C_NONE,
        C_NO_START,
        C_OPER_ZERO,
        C_GCD_BUSY,
        C_DIV_BUSY,
        C_MORE,
        C_CMD0,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic oper_zero;
        logic gcd_busy;
        logic div_busy;
        logic more;
        logic cmd0;
    } t_dp_stat;

    localparam t_pc PC_WAIT   = 4'd0;
    localparam t_pc PC_INIT   = 4'd1;
    localparam t_pc PC_GCD    = 4'd2;
    localparam t_pc PC_DIVN_I = 4'd3;
    localparam t_pc PC_DIVN   = 4'd4;
    localparam t_pc PC_STN    = 4'd5;
    localparam t_pc PC_DIVD_I = 4'd6;
    localparam t_pc PC_DIVD   = 4'd7;
    localparam t_pc PC_STD    = 4'd8;
    localparam t_pc PC_NEXT   = 4'd9;
    localparam t_pc PC_MUL1   = 4'd10;
    localparam t_pc PC_MUL2   = 4'd11;
    localparam t_pc PC_MUL3   = 4'd12;
    localparam t_pc PC_EMIT   = 4'd13;

    function automatic t_uword frc_ucode(input t_pc pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_NONE, target: PC_WAIT};
        unique case (pc)
            PC_WAIT:   w = '{op: OP_NOP,        cond: C_NO_START,  target: PC_WAIT};
            PC_INIT:   w = '{op: OP_GCD_INIT,   cond: C_OPER_ZERO, target: PC_EMIT};
            PC_GCD:    w = '{op: OP_GCD_STEP,   cond: C_GCD_BUSY,  target: PC_GCD};
            PC_DIVN_I: w = '{op: OP_DIV_INIT_N, cond: C_NONE,      target: PC_WAIT};
            PC_DIVN:   w = '{op: OP_DIV_STEP,   cond: C_DIV_BUSY,  target: PC_DIVN};
            PC_STN:    w = '{op: OP_STORE_N,    cond: C_NONE,      target: PC_WAIT};
            PC_DIVD_I: w = '{op: OP_DIV_INIT_D, cond: C_NONE,      target: PC_WAIT};
            PC_DIVD:   w = '{op: OP_DIV_STEP,   cond: C_DIV_BUSY,  target: PC_DIVD};
            PC_STD:    w = '{op: OP_STORE_D,    cond: C_NONE,      target: PC_WAIT};
            PC_NEXT:   w = '{op: OP_SEL_NEXT,   cond: C_MORE,      target: PC_INIT};
            PC_MUL1:   w = '{op: OP_MUL_1,      cond: C_CMD0,      target: PC_EMIT};
            PC_MUL2:   w = '{op: OP_MUL_2,      cond: C_NONE,      target: PC_WAIT};
            PC_MUL3:   w = '{op: OP_MUL_3,      cond: C_NONE,      target: PC_WAIT};
            PC_EMIT:   w = '{op: OP_NOP,        cond: C_OUT_BUSY,  target: PC_EMIT};
            default:   w = '{op: OP_NOP,        cond: C_NONE,      target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/frc_dp.sv
// ----------------------------------------------------------------------------
// frc_dp: fraction datapath
// Operand registers, a subtract-and-shift gcd unit, a one-bit-per-cycle
// restoring divider and one shared multiplier, all driven by micro-operations.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_dp #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire frc_pkg::t_op     i_op,
    input  wire logic             i_cmd,
    input  wire logic [15:0]      i_num_a,
    input  wire logic [15:0]      i_den_a,
    input  wire logic [15:0]      i_num_b,
    input  wire logic [15:0]      i_den_b,
    output frc_pkg::t_dp_stat     o_stat,
    output logic                  o_empty_res,
    output frc_pkg::t_num_out     o_num_out,
    output frc_pkg::t_den_out     o_den_out
);

    localparam int VW = VALUE_WIDTH;
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int CW = $clog2(VALUE_WIDTH);

    typedef logic [VW-1:0] t_val;
    typedef logic [PW-1:0] t_prod;
    typedef logic [PW:0]   t_acc;
    typedef logic [CW-1:0] t_cnt;

    logic  r_cmd, n_cmd;
    logic  r_sel, n_sel;
    logic  r_ok,  n_ok;
    t_val  r_na, n_na, r_da, n_da, r_nb, n_nb, r_db, n_db;
    t_val  r_ga, n_ga, r_gb, n_gb;
    t_val  r_rem, n_rem, r_quo, n_quo;
    t_cnt  r_cnt, n_cnt;
    t_prod r_p, n_p;
    t_acc  r_acc, n_acc;

    t_val  cur_n, cur_d;
    t_val  mul_x, mul_y;
    t_prod mul_p;
    logic [VW:0] rem_sh;
    logic        sub_ok;
    logic        is_add;

    assign cur_n  = r_sel ? r_nb : r_na;
    assign cur_d  = r_sel ? r_db : r_da;
    assign is_add = (r_cmd == frc_pkg::CMD_ADD);

    // Restoring division step: remainder stays below the divisor.
    assign rem_sh = {r_rem, r_quo[VW-1]};
    assign sub_ok = (rem_sh >= {1'b0, r_ga});

    // One shared multiplier, operands chosen by the micro-operation.
    always_comb begin
        mul_x = r_na;
        mul_y = r_db;
        case (i_op)
            frc_pkg::OP_MUL_2: begin
                mul_x = r_nb;
                mul_y = r_da;
            end
            frc_pkg::OP_MUL_3: begin
                mul_x = r_da;
                mul_y = r_db;
            end
            default: begin
                mul_x = r_na;
                mul_y = r_db;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    always_comb begin
        n_cmd = r_cmd;
        n_sel = r_sel;
        n_ok  = r_ok;
        n_na  = r_na;
        n_da  = r_da;
        n_nb  = r_nb;
        n_db  = r_db;
        n_ga  = r_ga;
        n_gb  = r_gb;
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        n_p   = r_p;
        n_acc = r_acc;
        if (i_load) begin
            n_cmd = i_cmd;
            n_na  = t_val'(i_num_a);
            n_da  = t_val'(i_den_a);
            n_nb  = t_val'(i_num_b);
            n_db  = t_val'(i_den_b);
            n_sel = 1'b0;
            n_ok  = 1'b1;
        end else begin
            case (i_op)
                frc_pkg::OP_GCD_INIT: begin
                    n_ga = cur_n;
                    n_gb = cur_d;
                    if (cur_n == '0 || cur_d == '0) begin
                        n_ok = 1'b0;
                    end
                end
                frc_pkg::OP_GCD_STEP: begin
                    if (r_ga != r_gb) begin
                        if (!r_ga[0] && !r_gb[0]) begin
                            // Common factor of two: only at the start, while the
                            // gcd registers still equal the operand, so the
                            // operand is halved along with them.
                            n_ga = r_ga >> 1;
                            n_gb = r_gb >> 1;
                            if (r_sel) begin
                                n_nb = r_nb >> 1;
                                n_db = r_db >> 1;
                            end else begin
                                n_na = r_na >> 1;
                                n_da = r_da >> 1;
                            end
                        end else if (!r_ga[0]) begin
                            n_ga = r_ga >> 1;
                        end else if (!r_gb[0]) begin
                            n_gb = r_gb >> 1;
                        end else if (r_ga > r_gb) begin
                            n_ga = (r_ga - r_gb) >> 1;
                        end else begin
                            n_gb = (r_gb - r_ga) >> 1;
                        end
                    end
                end
                frc_pkg::OP_DIV_INIT_N: begin
                    n_rem = '0;
                    n_quo = cur_n;
                    n_cnt = '0;
                end
                frc_pkg::OP_DIV_INIT_D: begin
                    n_rem = '0;
                    n_quo = cur_d;
                    n_cnt = '0;
                end
                frc_pkg::OP_DIV_STEP: begin
                    n_rem = sub_ok ? t_val'(rem_sh - {1'b0, r_ga}) : t_val'(rem_sh);
                    n_quo = {r_quo[VW-2:0], sub_ok};
                    n_cnt = r_cnt + t_cnt'(1);
                end
                frc_pkg::OP_STORE_N: begin
                    if (r_sel) begin
                        n_nb = r_quo;
                    end else begin
                        n_na = r_quo;
                    end
                end
                frc_pkg::OP_STORE_D: begin
                    if (r_sel) begin
                        n_db = r_quo;
                    end else begin
                        n_da = r_quo;
                    end
                end
                frc_pkg::OP_SEL_NEXT: begin
                    n_sel = 1'b1;
                end
                frc_pkg::OP_MUL_1: begin
                    n_p = mul_p;
                end
                frc_pkg::OP_MUL_2: begin
                    n_acc = t_acc'(r_p);
                    n_p   = mul_p;
                end
                frc_pkg::OP_MUL_3: begin
                    n_acc = r_acc + t_acc'(r_p);
                    n_p   = mul_p;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_sel <= n_sel;
        r_ok  <= n_ok;
        r_na  <= n_na;
        r_da  <= n_da;
        r_nb  <= n_nb;
        r_db  <= n_db;
        r_ga  <= n_ga;
        r_gb  <= n_gb;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_p   <= n_p;
        r_acc <= n_acc;
    end

    assign o_stat.oper_zero = (cur_n == '0) || (cur_d == '0);
    assign o_stat.gcd_busy  = (r_ga != r_gb);
    assign o_stat.div_busy  = (r_cnt != t_cnt'(VW - 1));
    assign o_stat.more      = is_add && !r_sel;
    assign o_stat.cmd0      = (r_cmd == frc_pkg::CMD_REDUCE);

    assign o_empty_res = !r_ok;
    assign o_num_out   = !r_ok ? '0 :
                         (is_add ? frc_pkg::t_num_out'(r_acc) : frc_pkg::t_num_out'(r_na));
    assign o_den_out   = !r_ok ? '0 :
                         (is_add ? frc_pkg::t_den_out'(r_p) : frc_pkg::t_den_out'(r_da));

    a_div_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == frc_pkg::OP_DIV_STEP |-> r_rem < r_ga)
        else $error("divider remainder not below divisor");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == frc_pkg::OP_GCD_STEP |-> r_ga != '0 && r_gb != '0)
        else $error("gcd operand reached zero");

    a_divisor_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == frc_pkg::OP_DIV_INIT_N || i_op == frc_pkg::OP_DIV_INIT_D)
        |-> r_ga == r_gb)
        else $error("division started before gcd converged");

endmodule

`default_nettype wire

// File: rtl/fraction_reduce_and_add.sv
// ----------------------------------------------------------------------------
// fraction_reduce_and_add: reduce one fraction or add two fractions
// Microcoded sequencer over a shared gcd/divide/multiply datapath.
//
//   Channel  Direction  Handshake           Fields
//   input    in         i_valid / o_stall   i_cmd, i_num_a, i_den_a, i_num_b, i_den_b
//   output   out        o_valid / i_stall   o_empty_res, o_num_out, o_den_out
//
// One transaction is processed at a time. Per operand: one setup step, the
// subtract-and-shift gcd loop, then two bit-serial divisions. Command 0 reduces
// one operand, command 1 reduces two and adds 3 multiply/add steps; an invalid
// operand ends the work at once. Reset is synchronous and needs no clearing
// pass. The result waits in an output register; a stalled output only holds
// the sequencer at its emit step, after the next transaction is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_reduce_and_add #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_cmd,
    input  wire logic [15:0] i_num_a,
    input  wire logic [15:0] i_den_a,
    input  wire logic [15:0] i_num_b,
    input  wire logic [15:0] i_den_b,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_empty_res,
    output logic [32:0]      o_num_out,
    output logic [31:0]      o_den_out
);

    frc_pkg::t_pc      r_pc, n_pc;
    logic              r_ovalid, n_ovalid;
    logic              r_oempty;
    frc_pkg::t_num_out r_onum;
    frc_pkg::t_den_out r_oden;

    frc_pkg::t_uword   uw;
    frc_pkg::t_dp_stat stat;
    logic              accept;
    logic              out_busy;
    logic              out_load;
    logic              jump;
    logic              dp_empty;
    frc_pkg::t_num_out dp_num;
    frc_pkg::t_den_out dp_den;

    assign uw       = frc_pkg::frc_ucode(r_pc);
    assign o_stall  = (r_pc != frc_pkg::PC_WAIT);
    assign accept   = i_valid && !o_stall;
    assign out_busy = r_ovalid && i_stall;
    assign out_load = (r_pc == frc_pkg::PC_EMIT) && !out_busy;

    frc_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_op        (uw.op),
        .i_cmd       (i_cmd),
        .i_num_a     (i_num_a),
        .i_den_a     (i_den_a),
        .i_num_b     (i_num_b),
        .i_den_b     (i_den_b),
        .o_stat      (stat),
        .o_empty_res (dp_empty),
        .o_num_out   (dp_num),
        .o_den_out   (dp_den)
    );

    always_comb begin
        case (uw.cond)
            frc_pkg::C_NONE:      jump = 1'b0;
            frc_pkg::C_NO_START:  jump = !accept;
            frc_pkg::C_OPER_ZERO: jump = stat.oper_zero;
            frc_pkg::C_GCD_BUSY:  jump = stat.gcd_busy;
            frc_pkg::C_DIV_BUSY:  jump = stat.div_busy;
            frc_pkg::C_MORE:      jump = stat.more;
            frc_pkg::C_CMD0:      jump = stat.cmd0;
            frc_pkg::C_OUT_BUSY:  jump = out_busy;
            default:              jump = 1'b0;
        endcase
    end

    always_comb begin
        if (jump) begin
            n_pc = uw.target;
        end else if (r_pc == frc_pkg::PC_EMIT) begin
            n_pc = frc_pkg::PC_WAIT;
        end else begin
            n_pc = r_pc + frc_pkg::t_pc'(1);
        end
        n_ovalid = out_load || out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= frc_pkg::PC_WAIT;
            r_ovalid <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oempty <= dp_empty;
            r_onum   <= dp_num;
            r_oden   <= dp_den;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_empty_res = r_oempty;
    assign o_num_out   = r_onum;
    assign o_den_out   = r_oden;

    a_start_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_pc == frc_pkg::PC_INIT)
        else $error("sequencer did not start after an accepted transaction");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_pc == frc_pkg::PC_EMIT))
        else $error("result presented outside the emit step");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oempty) |-> (r_onum == '0 && r_oden == '0))
        else $error("empty result carries nonzero fields");

endmodule

`default_nettype wire
